>>> rtl/lkv_pkg.sv
// Shared types, constants and helpers for the LRU key-value cache.
// No dependencies; every other file of the block imports this package.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (USED_W > CAP_W) ? USED_W : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_DATA = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] PUT_DATA  = '0;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } lkv_request_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_data;
    logic                     evicted;
  } lkv_result_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } lkv_entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             lookup;
    logic             update;
    logic             hit;
    logic             evict;
    logic [KEY_W-1:0] key;
  } lkv_ctrl_t;

  // Capacity register clamped to 1..MAX_ENTRIES.
  function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    c = CMP_W'(cap);
    if (c == '0) c = CMP_W'(1);
    if (c > CMP_W'(MAX_ENTRIES)) c = CMP_W'(MAX_ENTRIES);
    return c;
  endfunction

endpackage

>>> rtl/lkv_cell.sv
// One cache cell: holds one entry; cells are ordered by recency, cell 0 newest.
// Depends on lkv_pkg.
module lkv_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  lkv_pkg::lkv_ctrl_t        ctrl,
  input  lkv_pkg::lkv_entry_t       prev_entry,
  input  logic                      prev_seen,
  input  logic [lkv_pkg::DATA_W-1:0] prev_found,
  output lkv_pkg::lkv_entry_t       entry,
  output logic                      seen,
  output logic [lkv_pkg::DATA_W-1:0] found
);
  import lkv_pkg::*;

  logic              valid;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] data;
  logic              match;
  logic              match_now;
  logic              shift_en;

  assign entry     = '{valid: valid, key: key, data: data};
  assign match_now = valid && (key == ctrl.key);
  assign found     = prev_found | (match_now ? data : '0);
  assign seen      = prev_seen | match;

  // Hit: cells up to the hit one shift. Miss with eviction: every valid cell
  // shifts and the oldest drops out. Miss without: valid cells shift, the first free cell fills.
  always_comb begin
    if (ctrl.hit) begin
      shift_en = !prev_seen;
    end else if (ctrl.evict) begin
      shift_en = valid;
    end else begin
      shift_en = prev_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.lookup) match <= match_now;
      if (ctrl.update && shift_en) valid <= prev_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && shift_en) begin
      key  <= prev_entry.key;
      data <= prev_entry.data;
    end
  end

endmodule

>>> rtl/lkv_row.sv
// Row of MAX_ENTRIES cells linked newest to oldest, with the hit data OR chain.
// Depends on lkv_pkg and lkv_cell.
module lkv_row (
  input  logic                       clk,
  input  logic                       rst,
  input  lkv_pkg::lkv_ctrl_t         ctrl,
  input  lkv_pkg::lkv_entry_t        head,
  output logic                       hit,
  output logic [lkv_pkg::DATA_W-1:0] hit_data
);
  import lkv_pkg::*;

  lkv_entry_t        entry_link [0:MAX_ENTRIES];
  logic              seen_link  [0:MAX_ENTRIES];
  logic [DATA_W-1:0] found_link [0:MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_vec;

  assign entry_link[0] = head;
  assign seen_link[0]  = 1'b0;
  assign found_link[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_entry (entry_link[i]),
      .prev_seen  (seen_link[i]),
      .prev_found (found_link[i]),
      .entry      (entry_link[i+1]),
      .seen       (seen_link[i+1]),
      .found      (found_link[i+1])
    );
    assign match_vec[i] = entry_link[i+1].valid && (entry_link[i+1].key == ctrl.key);
  end

  // Keys are unique, so at most one cell matches and the OR chain is the data.
  assign hit      = |match_vec;
  assign hit_data = found_link[MAX_ENTRIES];

endmodule

>>> rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request control, capacity register,
// result register. Depends on lkv_pkg, lkv_row and lkv_cell.
//
//   port group   dir  handshake            payload
//   req          in   req_valid/req_stall  lkv_request_t (cmd, lookup_key, write_value)
//   rsp          out  rsp_valid/rsp_stall  lkv_result_t  (hit, read_data, evicted)
//   cfg          in   cfg_valid/cfg_ready  capacity_in_use, 5 bits
//
// Each item passes a compare step, comparing the key in every cell, then a
// shift step for the recency chain; the next item is taken in the shift step.
// Reset clears all valid marks, the fill count and sets capacity to 16.
// A stalled result holds the shift cycle until the result register frees.
module lru_key_value_cache (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  lkv_pkg::lkv_request_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output lkv_pkg::lkv_result_t  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);
  import lkv_pkg::*;

  lkv_state_t        state, state_next;
  lkv_request_t      cur;
  logic [CAP_W-1:0]  capacity;
  logic [USED_W-1:0] used;
  logic              hit_q;
  logic [DATA_W-1:0] hit_data_q;
  logic              row_hit;
  logic [DATA_W-1:0] row_data;
  logic              out_free;
  logic              commit;
  logic              accept;
  logic              lookup;
  logic              is_put;
  logic              evict;
  lkv_ctrl_t         ctrl;
  lkv_entry_t        head;
  lkv_result_t       result;

  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign is_put    = (cur.cmd == CMD_PUT);
  assign evict     = is_put && !hit_q && (CMP_W'(used) >= eff_cap(capacity));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (commit) state_next = accept ? ST_LOOKUP : ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    commit    = 1'b0;
    lookup    = 1'b0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE:   req_stall = 1'b0;
      ST_LOOKUP: lookup = 1'b1;
      ST_UPDATE: begin
        commit    = out_free;
        req_stall = !out_free;
      end
      default:   req_stall = 1'b1;
    endcase
  end

  assign accept = req_valid && !req_stall;

  assign ctrl = '{lookup: lookup,
                  update: commit && (hit_q || is_put),
                  hit:    hit_q,
                  evict:  evict,
                  key:    cur.lookup_key};

  assign head = '{valid: 1'b1,
                  key:   cur.lookup_key,
                  data:  is_put ? cur.write_value : hit_data_q};

  always_comb begin
    result.hit     = hit_q;
    result.evicted = evict;
    if (is_put) begin
      result.read_data = PUT_DATA;
    end else if (hit_q) begin
      result.read_data = hit_data_q;
    end else begin
      result.read_data = MISS_DATA;
    end
  end

  lkv_row u_row (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .head     (head),
    .hit      (row_hit),
    .hit_data (row_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (commit && is_put && !hit_q && !evict) used <= used + USED_W'(1);
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= req;
    if (lookup) begin
      hit_q      <= row_hit;
      hit_data_q <= row_data;
    end
    if (commit) rsp <= result;
  end

endmodule

>>> rtl/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
module lkv_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_stall,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input lkv_pkg::lkv_result_t  rsp
);
  import lkv_pkg::*;

  // A held result stays put until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The compare cycle follows every taken item, so no item is taken right after.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item taken in the compare cycle");

  // Eviction only happens on a put of an absent key.
  a_evict_is_put_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> !rsp.hit && rsp.read_data == PUT_DATA)
    else $error("eviction reported on a hit or a get");

  // A miss returns either the put code or the miss code.
  a_miss_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.read_data == PUT_DATA || rsp.read_data == MISS_DATA)
    else $error("miss returned stored data");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
